// ===== sv/erb_pkg.sv =====
package erb_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Fast-mono latency range
  localparam logic [15:0] FAST_MIN_MS = 16'd200;
  localparam logic [15:0] FAST_MAX_MS = 16'd400;

  // Configuration reset values
  localparam logic [15:0] FULL_MIN_RST    = 16'd2000;
  localparam logic [15:0] FULL_MAX_RST    = 16'd3000;
  localparam logic [15:0] PARTIAL_MIN_RST = 16'd300;
  localparam logic [15:0] PARTIAL_MAX_RST = 16'd500;
  localparam logic [15:0] CLEAR_RST       = 16'd4000;

  // Percentage scale
  localparam logic [6:0] PCT_SCALE = 7'd100;

  // Shared divider: the quotient always fits in DIV_Q_W bits
  localparam int unsigned DIV_NUM_W = 48;
  localparam int unsigned DIV_DEN_W = 32;
  localparam int unsigned DIV_Q_W   = 16;
  localparam int unsigned DIV_CNT_W = 4;

  typedef enum logic [1:0] {
    MODE_FULL    = 2'd0,
    MODE_PARTIAL = 2'd1,
    MODE_FAST    = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PANEL_WIDTH    = 3'd0,
    CFG_PANEL_HEIGHT   = 3'd1,
    CFG_PARTIAL_BUDGET = 3'd2,
    CFG_FULL_MIN_MS    = 3'd3,
    CFG_FULL_MAX_MS    = 3'd4,
    CFG_PARTIAL_MIN_MS = 3'd5,
    CFG_PARTIAL_MAX_MS = 3'd6,
    CFG_CLEAR_MS       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] panel_width;
    logic [15:0] panel_height;
    logic [15:0] partial_budget;
    logic [15:0] full_min_ms;
    logic [15:0] full_max_ms;
    logic [15:0] partial_min_ms;
    logic [15:0] partial_max_ms;
    logic [15:0] clear_ms;
  } cfg_t;

  // Clipped request as it travels from front to back
  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cw;
    logic [15:0] ch;
    mode_t       mode;
  } item_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_MUL      = 3'd1,
    S_PREP     = 3'd2,
    S_PCT_GO   = 3'd3,
    S_PCT_WAIT = 3'd4,
    S_LAT_GO   = 3'd5,
    S_LAT_WAIT = 3'd6,
    S_FIN      = 3'd7
  } back_state_t;

endpackage

// ===== sv/erb_front.sv =====
module erb_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_whole_panel,
  input  logic [15:0]    in_req_x,
  input  logic [15:0]    in_req_y,
  input  logic [15:0]    in_req_w,
  input  logic [15:0]    in_req_h,
  input  logic [1:0]     in_req_mode,
  input  erb_pkg::cfg_t  cfg,
  input  erb_pkg::qstat_t q_stat,
  output logic           push,
  output erb_pkg::item_t item
);
  import erb_pkg::*;

  logic [16:0] x_end;
  logic [16:0] y_end;

  // Accept whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  assign x_end = {1'b0, in_req_x} + {1'b0, in_req_w};
  assign y_end = {1'b0, in_req_y} + {1'b0, in_req_h};

  // Clip the rectangle to the panel
  always_comb begin
    item.mode = mode_t'(in_req_mode);
    if (in_whole_panel) begin
      item.cx = '0;
      item.cy = '0;
      item.cw = cfg.panel_width;
      item.ch = cfg.panel_height;
    end else if (in_req_x >= cfg.panel_width || in_req_y >= cfg.panel_height) begin
      item.cx = '0;
      item.cy = '0;
      item.cw = '0;
      item.ch = '0;
    end else begin
      item.cx = in_req_x;
      item.cy = in_req_y;
      item.cw = (x_end > {1'b0, cfg.panel_width}) ? (cfg.panel_width - in_req_x) : in_req_w;
      item.ch = (y_end > {1'b0, cfg.panel_height}) ? (cfg.panel_height - in_req_y) : in_req_h;
    end
  end

endmodule

// ===== sv/erb_queue.sv =====
module erb_queue #(
  parameter int unsigned DEPTH = erb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  erb_pkg::item_t  wr_item,
  input  logic            pop,
  output erb_pkg::item_t  rd_item,
  output erb_pkg::qstat_t q_stat
);
  import erb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.valid = (count_r != '0);
  assign rd_item      = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== sv/erb_div.sv =====
module erb_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [erb_pkg::DIV_NUM_W-1:0]  num,
  input  logic [erb_pkg::DIV_DEN_W-1:0]  den,
  output logic                           done,
  output logic [erb_pkg::DIV_Q_W-1:0]    quot
);
  import erb_pkg::*;

  // Restoring divider, one quotient bit a cycle. The upper numerator bits
  // must already be below the divisor, so only the low DIV_Q_W bits iterate.
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_Q_W-1:0]   sh_r, sh_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign trial = {rem_r, sh_r[DIV_Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});
  assign done  = done_r;
  assign quot  = sh_r;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num[DIV_NUM_W-1:DIV_Q_W];
      sh_nxt   = num[DIV_Q_W-1:0];
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Subtract where it fits, shift the quotient bit in
      rem_nxt = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      sh_nxt  = {sh_r[DIV_Q_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_Q_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    sh_r  <= sh_nxt;
  end

endmodule

// ===== sv/erb_back.sv =====
module erb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  erb_pkg::cfg_t   cfg,
  input  erb_pkg::qstat_t q_stat,
  input  erb_pkg::item_t  q_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_clip_x,
  output logic [15:0]     out_clip_y,
  output logic [15:0]     out_clip_w,
  output logic [15:0]     out_clip_h,
  output logic [1:0]      out_done_mode,
  output logic            out_was_forced,
  output logic [6:0]      out_cover_percent,
  output logic [15:0]     out_took_ms,
  output logic [15:0]     out_partial_run,
  output logic [31:0]     out_flush_total,
  output logic [31:0]     out_forced_total,
  output logic [31:0]     out_time_total_ms
);
  import erb_pkg::*;

  back_state_t state_r, state_nxt;

  // Work registers
  item_t        item_r, item_nxt;
  logic [31:0]  panel_r, panel_nxt;
  logic [31:0]  cover_r, cover_nxt;
  mode_t        done_r, done_nxt;
  logic         forced_r, forced_nxt;
  logic [15:0]  lo_r, lo_nxt;
  logic [15:0]  span_r, span_nxt;
  logic [38:0]  pct_num_r, pct_num_nxt;
  logic [47:0]  lat_num_r, lat_num_nxt;
  logic [6:0]   pct_r, pct_nxt;

  // Running state
  logic [15:0]  pcount_r, pcount_nxt;
  logic [31:0]  forced_cnt_r, forced_cnt_nxt;
  logic [31:0]  flush_cnt_r, flush_cnt_nxt;
  logic [31:0]  time_r, time_nxt;

  // Output register
  logic         out_valid_r, out_valid_nxt;
  logic [15:0]  out_took_r, out_took_nxt;

  // Divider hookup
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic                 div_done;
  logic [DIV_Q_W-1:0]   div_quot;

  // Decision helpers
  logic         forced_now;
  mode_t        done_now;
  logic [15:0]  lo_sel;
  logic [15:0]  hi_sel;
  logic [15:0]  took_now;
  logic [15:0]  lat_q;

  erb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (panel_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Budget check and latency range of the performed mode
  always_comb begin
    forced_now = (item_r.mode == MODE_PARTIAL || item_r.mode == MODE_FAST) &&
                 (pcount_r >= cfg.partial_budget);
    done_now   = forced_now ? MODE_FULL : item_r.mode;
    case (done_now)
      MODE_FULL: begin
        lo_sel = cfg.full_min_ms;
        hi_sel = cfg.full_max_ms;
      end
      MODE_PARTIAL: begin
        lo_sel = cfg.partial_min_ms;
        hi_sel = cfg.partial_max_ms;
      end
      MODE_FAST: begin
        lo_sel = FAST_MIN_MS;
        hi_sel = FAST_MAX_MS;
      end
      MODE_CLEAR: begin
        lo_sel = cfg.clear_ms;
        hi_sel = cfg.clear_ms;
      end
      default: begin
        lo_sel = cfg.full_min_ms;
        hi_sel = cfg.full_max_ms;
      end
    endcase
  end

  // Empty panel gives no interpolation
  assign lat_q    = (panel_r == '0) ? '0 : div_quot;
  assign took_now = lo_r + lat_q;
  assign div_num  = (state_r == S_PCT_GO) ? DIV_NUM_W'(pct_num_r) : lat_num_r;

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    panel_nxt      = panel_r;
    cover_nxt      = cover_r;
    done_nxt       = done_r;
    forced_nxt     = forced_r;
    lo_nxt         = lo_r;
    span_nxt       = span_r;
    pct_num_nxt    = pct_num_r;
    lat_num_nxt    = lat_num_r;
    pct_nxt        = pct_r;
    pcount_nxt     = pcount_r;
    forced_cnt_nxt = forced_cnt_r;
    flush_cnt_nxt  = flush_cnt_r;
    time_nxt       = time_r;
    out_valid_nxt  = out_valid_r;
    out_took_nxt   = out_took_r;
    pop            = 1'b0;
    div_start      = 1'b0;

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_stat.valid) begin
          pop       = 1'b1;
          item_nxt  = q_item;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        panel_nxt  = cfg.panel_width * cfg.panel_height;
        cover_nxt  = item_r.cw * item_r.ch;
        done_nxt   = done_now;
        forced_nxt = forced_now;
        lo_nxt     = lo_sel;
        span_nxt   = (hi_sel < lo_sel) ? '0 : hi_sel - lo_sel;
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        pct_num_nxt = 39'(cover_r) * 39'(PCT_SCALE) + 39'(panel_r >> 1);
        lat_num_nxt = 48'(span_r) * 48'(cover_r);
        if (panel_r == '0) begin
          pct_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_PCT_GO;
        end
      end
      S_PCT_GO: begin
        div_start = 1'b1;
        state_nxt = S_PCT_WAIT;
      end
      S_PCT_WAIT: begin
        if (div_done) begin
          pct_nxt   = div_quot[6:0];
          state_nxt = S_LAT_GO;
        end
      end
      S_LAT_GO: begin
        div_start = 1'b1;
        state_nxt = S_LAT_WAIT;
      end
      S_LAT_WAIT: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_took_nxt   = took_now;
          pcount_nxt     = (done_r == MODE_FULL || done_r == MODE_CLEAR) ?
                           '0 : pcount_r + 1'b1;
          forced_cnt_nxt = forced_cnt_r + 32'(forced_r);
          flush_cnt_nxt  = flush_cnt_r + 1'b1;
          time_nxt       = time_r + 32'(took_now);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r     <= '0;
      forced_cnt_r <= '0;
      flush_cnt_r  <= '0;
      time_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pcount_r     <= pcount_nxt;
      forced_cnt_r <= forced_cnt_nxt;
      flush_cnt_r  <= flush_cnt_nxt;
      time_r       <= time_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    panel_r   <= panel_nxt;
    cover_r   <= cover_nxt;
    done_r    <= done_nxt;
    forced_r  <= forced_nxt;
    lo_r      <= lo_nxt;
    span_r    <= span_nxt;
    pct_num_r <= pct_num_nxt;
    lat_num_r <= lat_num_nxt;
    pct_r     <= pct_nxt;
    out_took_r <= out_took_nxt;
  end

  // Output fields; item and decision registers change at the next pop, which
  // can happen while a result is held, so the fields are captured at load
  logic [15:0] cx_hold_r, cy_hold_r, cw_hold_r, ch_hold_r;
  mode_t       mode_hold_r;
  logic        forced_hold_r;
  logic [6:0]  pct_hold_r;
  logic        load_out;

  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (load_out) begin
      cx_hold_r     <= item_r.cx;
      cy_hold_r     <= item_r.cy;
      cw_hold_r     <= item_r.cw;
      ch_hold_r     <= item_r.ch;
      mode_hold_r   <= done_r;
      forced_hold_r <= forced_r;
      pct_hold_r    <= pct_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_clip_x        = cx_hold_r;
  assign out_clip_y        = cy_hold_r;
  assign out_clip_w        = cw_hold_r;
  assign out_clip_h        = ch_hold_r;
  assign out_done_mode     = mode_hold_r;
  assign out_was_forced    = forced_hold_r;
  assign out_cover_percent = pct_hold_r;
  assign out_took_ms       = out_took_r;
  assign out_partial_run   = pcount_r;
  assign out_flush_total   = flush_cnt_r;
  assign out_forced_total  = forced_cnt_r;
  assign out_time_total_ms = time_r;

endmodule

// ===== sv/epd_refresh_budget_model.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_ready    whole_panel, req_x, req_y, req_w, req_h, req_mode
// out       out_valid / out_ready  clip_x..clip_h, done_mode, was_forced, cover_percent,
//                                  took_ms, partial_run, flush/forced/time totals
// cfg       cfg_we                 cfg_index, cfg_data (write only, no wait)
//
// In the back end a request passes through a pop, two multiply stages, then
// two passes of the shared 16-step restoring divider (cover percentage, then
// latency interpolation) and a finish state.
// An empty panel skips both divider passes.
// Reset (rst_n low, synchronous) clears the counters and queue and loads the
// default configuration. While out_ready is low the result holds, and the
// front keeps taking requests until the QUEUE_DEPTH-entry queue is full.
module epd_refresh_budget_model #(
  parameter int unsigned QUEUE_DEPTH = erb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_whole_panel,
  input  logic [15:0]                     in_req_x,
  input  logic [15:0]                     in_req_y,
  input  logic [15:0]                     in_req_w,
  input  logic [15:0]                     in_req_h,
  input  logic [1:0]                      in_req_mode,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [15:0]                     out_clip_x,
  output logic [15:0]                     out_clip_y,
  output logic [15:0]                     out_clip_w,
  output logic [15:0]                     out_clip_h,
  output logic [1:0]                      out_done_mode,
  output logic                            out_was_forced,
  output logic [6:0]                      out_cover_percent,
  output logic [15:0]                     out_took_ms,
  output logic [15:0]                     out_partial_run,
  output logic [31:0]                     out_flush_total,
  output logic [31:0]                     out_forced_total,
  output logic [31:0]                     out_time_total_ms,
  input  logic                            cfg_we,
  input  logic [erb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [erb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import erb_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  qstat_t q_stat;
  item_t  front_item;
  item_t  q_item;
  logic   push;
  logic   pop;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PANEL_WIDTH:    cfg_nxt.panel_width    = cfg_data;
        CFG_PANEL_HEIGHT:   cfg_nxt.panel_height   = cfg_data;
        CFG_PARTIAL_BUDGET: cfg_nxt.partial_budget = cfg_data;
        CFG_FULL_MIN_MS:    cfg_nxt.full_min_ms    = cfg_data;
        CFG_FULL_MAX_MS:    cfg_nxt.full_max_ms    = cfg_data;
        CFG_PARTIAL_MIN_MS: cfg_nxt.partial_min_ms = cfg_data;
        CFG_PARTIAL_MAX_MS: cfg_nxt.partial_max_ms = cfg_data;
        CFG_CLEAR_MS:       cfg_nxt.clear_ms       = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.panel_width    <= '0;
      cfg_r.panel_height   <= '0;
      cfg_r.partial_budget <= '0;
      cfg_r.full_min_ms    <= FULL_MIN_RST;
      cfg_r.full_max_ms    <= FULL_MAX_RST;
      cfg_r.partial_min_ms <= PARTIAL_MIN_RST;
      cfg_r.partial_max_ms <= PARTIAL_MAX_RST;
      cfg_r.clear_ms       <= CLEAR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  erb_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_whole_panel (in_whole_panel),
    .in_req_x       (in_req_x),
    .in_req_y       (in_req_y),
    .in_req_w       (in_req_w),
    .in_req_h       (in_req_h),
    .in_req_mode    (in_req_mode),
    .cfg            (cfg_r),
    .q_stat         (q_stat),
    .push           (push),
    .item           (front_item)
  );

  erb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .rd_item (q_item),
    .q_stat  (q_stat)
  );

  erb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_stat            (q_stat),
    .q_item            (q_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_clip_x        (out_clip_x),
    .out_clip_y        (out_clip_y),
    .out_clip_w        (out_clip_w),
    .out_clip_h        (out_clip_h),
    .out_done_mode     (out_done_mode),
    .out_was_forced    (out_was_forced),
    .out_cover_percent (out_cover_percent),
    .out_took_ms       (out_took_ms),
    .out_partial_run   (out_partial_run),
    .out_flush_total   (out_flush_total),
    .out_forced_total  (out_forced_total),
    .out_time_total_ms (out_time_total_ms)
  );

  // A forced refresh is always reported as full
  a_forced_is_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_forced |-> out_done_mode == MODE_FULL)
    else $error("forced refresh not reported as full");

  // Full and clear refreshes restart the partial run
  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_done_mode == MODE_FULL || out_done_mode == MODE_CLEAR)
      |-> out_partial_run == '0)
    else $error("partial run not cleared after full or clear refresh");

  // Coverage never exceeds the whole panel
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cover_percent <= PCT_SCALE)
    else $error("cover percentage above 100");

  // Each new result advances the flush count by one
  a_flush_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && $past(rst_n) |-> out_flush_total == $past(out_flush_total) + 32'd1)
    else $error("flush count did not advance by one");

endmodule
